// ===== sv/lir_pkg.sv =====
package lir_pkg;

    localparam int SAMPLE_W = 16;
    localparam int STEP_W   = 24;
    localparam int PH_W     = STEP_W + 2;
    localparam int MAX_OUT  = 64;
    localparam int CNT_W    = $clog2(MAX_OUT);

    localparam logic [STEP_W-1:0] STEP_RESET = 24'd65536;

    localparam int  PADDR_W        = 3;
    localparam logic REG_STEP_RATIO = 1'b0;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_RND  = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

endpackage

// ===== sv/linear_interp_resampler_top.sv =====
// channel   dir  signals                          fields (low bit up)
// s_        in   s_tvalid s_tready s_tdata[15:0]  in_sample
// m_        out  m_tvalid m_tready m_tdata[15:0]  out_sample
//                m_tlast                          last_of_run
// apb       in   psel penable pwrite paddr[2:0]   step_ratio at 0x0
//
// one input sample at a time; s_tready is high only while idle
// each result passes through the shared multiply/round unit (S_MUL, S_RND),
// then waits in S_OUT on m_tready; up to 64 results per input
// a priming or skipped input is taken in idle and gives no result
// aresetn is synchronous, active low; step_ratio resets to 65536
module linear_interp_resampler_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,

    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [15:0]                    s_tdata,   // in_sample

    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [15:0]                    m_tdata,   // out_sample
    output logic                           m_tlast,   // last_of_run

    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lir_pkg::PADDR_W-1:0]    paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    localparam int SW = lir_pkg::SAMPLE_W;
    localparam int PW = lir_pkg::PH_W;
    localparam logic [PW-1:0] ONE = PW'(1) << FRAC_BITS;
    localparam logic [lir_pkg::CNT_W-1:0] CNT_LAST = lir_pkg::CNT_W'(lir_pkg::MAX_OUT - 1);

    lir_pkg::state_t state_reg, state_next;

    logic [lir_pkg::STEP_W-1:0] step_reg;
    logic [lir_pkg::STEP_W-1:0] phase_reg;
    logic [PW-1:0]              ph_reg;
    logic [lir_pkg::CNT_W-1:0]  cnt_reg;
    logic                       primed_reg;
    logic signed [SW-1:0]       prev_reg;
    logic signed [SW-1:0]       cur_reg;
    logic [SW-1:0]              out_data_reg;
    logic                       out_last_reg;

    logic                       in_xfer;
    logic                       out_xfer;
    logic                       cfg_wr;
    logic [PW-1:0]              phase_ext;
    logic [PW-1:0]              ph_sum;
    logic                       sum_done;
    logic                       lerp_load;
    logic signed [SW-1:0]       lerp_y;

    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == lir_pkg::REG_STEP_RATIO) ? {8'd0, step_reg} : 32'd0;

    assign s_tready  = (state_reg == lir_pkg::S_IDLE);
    assign m_tvalid  = (state_reg == lir_pkg::S_OUT);
    assign m_tdata   = out_data_reg;
    assign m_tlast   = out_last_reg;
    assign in_xfer   = s_tvalid && s_tready;
    assign out_xfer  = m_tvalid && m_tready;

    assign phase_ext = {2'b00, phase_reg};
    assign ph_sum    = ph_reg + {2'b00, step_reg};
    assign sum_done  = (ph_sum >= ONE);
    assign lerp_load = (state_reg == lir_pkg::S_MUL);

    lir_lerp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_lerp (
        .aclk        (aclk),
        .load        (lerp_load),
        .prev_sample (prev_reg),
        .cur_sample  (cur_reg),
        .frac        (ph_reg[FRAC_BITS-1:0]),
        .y           (lerp_y)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lir_pkg::S_IDLE: begin
                if (in_xfer && primed_reg && (phase_ext < ONE)) begin
                    state_next = lir_pkg::S_MUL;
                end
            end
            lir_pkg::S_MUL: begin
                state_next = lir_pkg::S_RND;
            end
            lir_pkg::S_RND: begin
                state_next = lir_pkg::S_OUT;
            end
            lir_pkg::S_OUT: begin
                if (out_xfer) begin
                    state_next = out_last_reg ? lir_pkg::S_IDLE : lir_pkg::S_MUL;
                end
            end
            default: begin
                state_next = lir_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= lir_pkg::S_IDLE;
            step_reg   <= lir_pkg::STEP_RESET;
            phase_reg  <= '0;
            primed_reg <= 1'b0;
            prev_reg   <= '0;
            cnt_reg    <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr && (paddr[2] == lir_pkg::REG_STEP_RATIO)) begin
                step_reg <= pwdata[lir_pkg::STEP_W-1:0];
            end
            case (state_reg)
                lir_pkg::S_IDLE: begin
                    if (in_xfer) begin
                        cur_reg <= $signed(s_tdata);
                        ph_reg  <= phase_ext;
                        cnt_reg <= '0;
                        if (!primed_reg) begin
                            prev_reg   <= $signed(s_tdata);
                            primed_reg <= 1'b1;
                        end else if (phase_ext >= ONE) begin
                            // nothing to emit for this sample
                            prev_reg  <= $signed(s_tdata);
                            phase_reg <= lir_pkg::STEP_W'(phase_ext - ONE);
                        end
                    end
                end
                lir_pkg::S_RND: begin
                    out_data_reg <= lerp_y;
                    out_last_reg <= sum_done || (cnt_reg == CNT_LAST);
                end
                lir_pkg::S_OUT: begin
                    if (out_xfer) begin
                        if (out_last_reg) begin
                            prev_reg  <= cur_reg;
                            phase_reg <= sum_done ? lir_pkg::STEP_W'(ph_sum - ONE) : '0;
                        end else begin
                            ph_reg  <= ph_sum;
                            cnt_reg <= cnt_reg + 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input and result side active together");

    a_back_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> s_tready)
        else $error("no return to idle after final result");

    a_cap_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (cnt_reg == CNT_LAST)) |-> m_tlast)
        else $error("result count cap passed without tlast");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled result changed");
`endif

endmodule

// ===== sv/lir_lerp.sv =====
module lir_lerp #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                  aclk,
    input  logic                                  load,
    input  logic signed [lir_pkg::SAMPLE_W-1:0]   prev_sample,
    input  logic signed [lir_pkg::SAMPLE_W-1:0]   cur_sample,
    input  logic        [FRAC_BITS-1:0]           frac,
    output logic signed [lir_pkg::SAMPLE_W-1:0]   y
);

    localparam int DIFF_W = lir_pkg::SAMPLE_W + 1;
    localparam int PRD_W  = FRAC_BITS + DIFF_W + 1;
    localparam logic signed [PRD_W-1:0] HALF = PRD_W'(1) <<< (FRAC_BITS - 1);

    logic signed [DIFF_W-1:0]            diff;
    logic signed [FRAC_BITS:0]           frac_s;
    logic signed [PRD_W-1:0]             prod_reg;
    logic signed [lir_pkg::SAMPLE_W-1:0] base_reg;
    logic signed [PRD_W-1:0]             biased;
    logic signed [PRD_W-1:0]             shifted;
    logic signed [DIFF_W-1:0]            offset;
    logic signed [DIFF_W-1:0]            total;

    assign diff   = $signed({cur_sample[lir_pkg::SAMPLE_W-1], cur_sample})
                  - $signed({prev_sample[lir_pkg::SAMPLE_W-1], prev_sample});
    assign frac_s = $signed({1'b0, frac});

    // product stage
    always_ff @(posedge aclk) begin
        if (load) begin
            prod_reg <= diff * frac_s;
            base_reg <= prev_sample;
        end
    end

    // round half up, then add back the base sample
    assign biased  = prod_reg + HALF;
    assign shifted = biased >>> FRAC_BITS;
    assign offset  = shifted[DIFF_W-1:0];
    assign total   = $signed({base_reg[lir_pkg::SAMPLE_W-1], base_reg}) + offset;
    assign y       = total[lir_pkg::SAMPLE_W-1:0];

endmodule
